@@ rtl/ldpm_pkg.sv @@
`default_nettype none
package ldpm_pkg;

   localparam int unsigned IterDefault = 10;
   localparam int unsigned DivBits     = 34;
   localparam int unsigned DivLat      = 35;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusSat   = 2'd1;
   localparam logic [1:0] StatusRadial = 2'd2;

   localparam logic OpUndistort = 1'b0;
   localparam logic OpDistort   = 1'b1;

   localparam logic [2:0] RegFocalX  = 3'd0;
   localparam logic [2:0] RegFocalY  = 3'd1;
   localparam logic [2:0] RegCenterX = 3'd2;
   localparam logic [2:0] RegCenterY = 3'd3;
   localparam logic [2:0] RegK1      = 3'd4;
   localparam logic [2:0] RegK2      = 3'd5;
   localparam logic [2:0] RegP1      = 3'd6;
   localparam logic [2:0] RegP2      = 3'd7;

   typedef struct packed {
      logic [31:0]        focal_x;
      logic [31:0]        focal_y;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
   } cfg_type;

   // Per-item flags that travel down the pipeline alongside the data.
   typedef struct packed {
      logic       valid;
      logic       op;
      logic       clamped;
      logic       error;
   } tag_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647)       return 32'sh7fffffff;
      else if (v < -66'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   function automatic logic ovf32(input logic signed [65:0] v);
      return (v > 66'sd2147483647) || (v < -66'sd2147483648);
   endfunction

endpackage
`default_nettype wire

@@ rtl/ldpm_div.sv @@
`default_nettype none
// Pipelined restoring divider: signed numerator, positive divisor, quotient
// truncated toward zero. One quotient bit is resolved per stage.
module ldpm_div #(
   parameter int unsigned NumBits = 62,
   parameter int unsigned DenBits = 33,
   parameter int unsigned TagBits = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic signed [NumBits-1:0]  num,
   input  wire logic [DenBits-1:0]         den,
   input  wire logic [TagBits-1:0]         in_tag,
   output logic                            out_valid,
   output logic signed [NumBits:0]         quo,
   output logic [TagBits-1:0]              out_tag
);
   localparam int unsigned Steps = NumBits;

   logic [Steps:0]            vld_ff;
   logic [NumBits-1:0]        q_ff   [Steps+1];
   logic [DenBits:0]          rem_ff [Steps+1];
   logic [DenBits-1:0]        den_ff [Steps+1];
   logic                      neg_ff [Steps+1];
   logic [TagBits-1:0]        tag_ff [Steps+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Steps-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0]   <= num[NumBits-1] ? NumBits'(-num) : NumBits'(num);
      rem_ff[0] <= '0;
      den_ff[0] <= den;
      neg_ff[0] <= num[NumBits-1];
      tag_ff[0] <= in_tag;
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [DenBits:0]   trial;
      logic [DenBits+1:0] diff;
      always_comb begin
         trial = {rem_ff[s][DenBits-1:0], q_ff[s][NumBits-1]};
         diff  = {1'b0, trial} - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (!diff[DenBits+1]) begin
            rem_ff[s+1] <= diff[DenBits:0];
            q_ff[s+1]   <= {q_ff[s][NumBits-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= trial;
            q_ff[s+1]   <= {q_ff[s][NumBits-2:0], 1'b0};
         end
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign out_valid = vld_ff[Steps];
   assign out_tag   = tag_ff[Steps];
   assign quo = neg_ff[Steps] ? -$signed({1'b0, q_ff[Steps]})
                              :  $signed({1'b0, q_ff[Steps]});
endmodule
`default_nettype wire

@@ rtl/ldpm_model.sv @@
`default_nettype none
// Lens model terms for one point, four register stages deep.
module ldpm_model
   import ldpm_pkg::*;
#(
   parameter int unsigned TagBits = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                in_valid,
   input  wire logic signed [31:0]  x,
   input  wire logic signed [31:0]  y,
   input  wire logic [TagBits-1:0]  in_tag,
   output logic                     out_valid,
   output logic signed [31:0]       out_x,
   output logic signed [31:0]       out_y,
   output logic signed [31:0]       radial,
   output logic signed [31:0]       tx,
   output logic signed [31:0]       ty,
   output logic                     clamped,
   output logic [TagBits-1:0]       out_tag
);
   function automatic logic signed [65:0] qm(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return 66'(p >>> 28);
   endfunction

   logic [3:0] v_ff;
   logic [TagBits-1:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [31:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;
   logic signed [31:0] xx_ff, yy_ff, xy_ff;
   logic               c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [31:0] r2_ff, xy2_ff, ax_ff, ay_ff;
   logic signed [31:0] r4_ff, kr2_ff, pxy_ff, pax_ff, pay_ff, qxy_ff;
   logic signed [31:0] rad_ff, tx_ff, ty_ff;

   logic signed [65:0] xx_in, yy_in, xy_in, r2_in, ax_in, ay_in;
   logic signed [65:0] r4_in, kr2_in, pxy_in, pax_in, pay_in, qxy_in;
   logic signed [65:0] k2r4, rad_in, tx_in, ty_in;

   always_comb begin
      xx_in  = qm(x, x);
      yy_in  = qm(y, y);
      xy_in  = qm(x, y);
      r2_in  = 66'(xx_ff) + 66'(yy_ff);
      ax_in  = 66'(sat32(r2_in)) + 66'(xx_ff) * 2;
      ay_in  = 66'(sat32(r2_in)) + 66'(yy_ff) * 2;
      r4_in  = qm(r2_ff, r2_ff);
      kr2_in = qm(cfg.k1, r2_ff);
      pxy_in = qm(cfg.p1, xy2_ff);
      pax_in = qm(cfg.p2, ax_ff);
      pay_in = qm(cfg.p1, ay_ff);
      qxy_in = qm(cfg.p2, xy2_ff);
      k2r4   = qm(cfg.k2, r4_ff);
      rad_in = 66'sd268435456 + 66'(kr2_ff) + 66'(sat32(k2r4));
      tx_in  = 66'(pxy_ff) * 2 + 66'(pax_ff);
      ty_in  = 66'(pay_ff) + 66'(qxy_ff) * 2;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      x1_ff <= x; y1_ff <= y; t1_ff <= in_tag;
      xx_ff <= sat32(xx_in); yy_ff <= sat32(yy_in); xy_ff <= sat32(xy_in);
      c1_ff <= ovf32(xx_in) | ovf32(yy_in) | ovf32(xy_in);

      x2_ff <= x1_ff; y2_ff <= y1_ff; t2_ff <= t1_ff;
      r2_ff <= sat32(r2_in); xy2_ff <= xy_ff;
      ax_ff <= sat32(ax_in); ay_ff <= sat32(ay_in);
      c2_ff <= c1_ff | ovf32(r2_in) | ovf32(ax_in) | ovf32(ay_in);

      x3_ff <= x2_ff; y3_ff <= y2_ff; t3_ff <= t2_ff;
      r4_ff <= sat32(r4_in); kr2_ff <= sat32(kr2_in); pxy_ff <= sat32(pxy_in);
      pax_ff <= sat32(pax_in); pay_ff <= sat32(pay_in); qxy_ff <= sat32(qxy_in);
      c3_ff <= c2_ff | ovf32(r4_in) | ovf32(kr2_in) | ovf32(pxy_in)
             | ovf32(pax_in) | ovf32(pay_in) | ovf32(qxy_in);

      x4_ff <= x3_ff; y4_ff <= y3_ff; t4_ff <= t3_ff;
      rad_ff <= sat32(rad_in); tx_ff <= sat32(tx_in); ty_ff <= sat32(ty_in);
      c4_ff <= c3_ff | ovf32(k2r4) | ovf32(rad_in) | ovf32(tx_in) | ovf32(ty_in);
   end

   assign out_valid = v_ff[3];
   assign out_x = x4_ff;
   assign out_y = y4_ff;
   assign radial = rad_ff;
   assign tx = tx_ff;
   assign ty = ty_ff;
   assign clamped = c4_ff;
   assign out_tag = t4_ff;
endmodule
`default_nettype wire

@@ rtl/ldpm_iter.sv @@
`default_nettype none
// One undistortion step (or the single distortion step): model terms, then
// either x*radial+tx or (xn-tx)/radial through pipelined dividers. A
// distortion transaction is only worked on in the first step; every later
// step passes its coordinates and flags through unchanged.
module ldpm_iter
   import ldpm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               first_step,
   input  wire logic               in_valid,
   input  wire tag_type            in_tag,
   input  wire logic signed [31:0] xn,
   input  wire logic signed [31:0] yn,
   input  wire logic signed [31:0] x,
   input  wire logic signed [31:0] y,
   output logic                    out_valid,
   output tag_type                 out_tag,
   output logic signed [31:0]      out_xn,
   output logic signed [31:0]      out_yn,
   output logic signed [31:0]      out_x,
   output logic signed [31:0]      out_y
);
   localparam int unsigned MTag = $bits(tag_type) + 64;
   localparam int unsigned DTag = $bits(tag_type) + 64 + 64;

   logic                     m_valid, m_clamp;
   logic signed [31:0]       m_x, m_y, m_rad, m_tx, m_ty;
   logic [MTag-1:0]          m_tag;
   tag_type                  mt;
   logic signed [31:0]       m_xn, m_yn;

   ldpm_model #(.TagBits(MTag)) u_model (
      .clock, .reset, .cfg,
      .in_valid(in_valid), .x(x), .y(y), .in_tag({in_tag, xn, yn}),
      .out_valid(m_valid), .out_x(m_x), .out_y(m_y), .radial(m_rad),
      .tx(m_tx), .ty(m_ty), .clamped(m_clamp), .out_tag(m_tag)
   );

   always_comb begin
      mt   = m_tag[MTag-1 -: $bits(tag_type)];
      m_xn = m_tag[63:32];
      m_yn = m_tag[31:0];
   end

   // Distort products and divider operands.
   logic signed [63:0] px, py;
   logic signed [65:0] dx, dy;
   logic signed [32:0] nx, ny;
   logic               rad_bad;
   logic               use_terms;
   tag_type            dt_in;
   always_comb begin
      px = m_x * m_rad;
      py = m_y * m_rad;
      // The product saturates on its own before tx is added.
      dx = 66'(sat32(66'(px >>> 28))) + 66'(m_tx);
      dy = 66'(sat32(66'(py >>> 28))) + 66'(m_ty);
      nx = 33'(m_xn) - 33'(m_tx);
      ny = 33'(m_yn) - 33'(m_ty);
      rad_bad = (m_rad <= 0);
      use_terms = first_step || (mt.op == OpUndistort);
      dt_in = mt;
      dt_in.clamped = mt.clamped | (m_valid && !mt.error && use_terms && m_clamp);
      if (mt.op == OpUndistort && !mt.error && rad_bad) dt_in.error = 1'b1;
   end

   // Distort result computed with the first register, carried through tag.
   logic signed [31:0] dres_x, dres_y;
   logic               dres_c;
   always_comb begin
      dres_x = first_step ? sat32(dx) : m_x;
      dres_y = first_step ? sat32(dy) : m_y;
      dres_c = first_step & (ovf32(dx) | ovf32(dy)
             | ovf32(66'(px >>> 28)) | ovf32(66'(py >>> 28)));
   end

   logic [DTag-1:0] dtag_in, dtag_out;
   tag_type         ot;
   logic signed [31:0] o_xn, o_yn, o_dx, o_dy;
   logic            dv_x, dv_y, dist_c;
   logic signed [62:0] qx, qy;
   logic [DTag-1:0] unused_tag;

   always_comb begin
      tag_type t;
      t = dt_in;
      if (mt.op == OpDistort && !mt.error) t.clamped = dt_in.clamped | dres_c;
      dtag_in = {t, m_xn, m_yn, dres_x, dres_y};
   end

   ldpm_div #(.NumBits(62), .DenBits(32), .TagBits(DTag)) u_div_x (
      .clock, .reset, .in_valid(m_valid),
      .num({nx, 29'd0}), .den(rad_bad ? 32'd1 : 32'(m_rad)), .in_tag(dtag_in),
      .out_valid(dv_x), .quo(qx), .out_tag(dtag_out)
   );
   ldpm_div #(.NumBits(62), .DenBits(32), .TagBits(DTag)) u_div_y (
      .clock, .reset, .in_valid(m_valid),
      .num({ny, 29'd0}), .den(rad_bad ? 32'd1 : 32'(m_rad)), .in_tag(dtag_in),
      .out_valid(dv_y), .quo(qy), .out_tag(unused_tag)
   );

   // Numerator above is (n*2^29); halve the quotient toward zero.
   logic signed [65:0] ux, uy;
   always_comb begin
      ot   = dtag_out[DTag-1 -: $bits(tag_type)];
      o_xn = dtag_out[127:96];
      o_yn = dtag_out[95:64];
      o_dx = dtag_out[63:32];
      o_dy = dtag_out[31:0];
      ux = 66'(qx) / 2;
      uy = 66'(qy) / 2;
      dist_c = ovf32(ux) | ovf32(uy);
   end

   logic               v_ff;
   tag_type            t_ff;
   logic signed [31:0] xn_ff, yn_ff, x_ff, y_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else       v_ff <= dv_x & dv_y;
   end
   always_ff @(posedge clock) begin
      xn_ff <= o_xn;
      yn_ff <= o_yn;
      if (ot.op == OpDistort || ot.error) begin
         t_ff <= ot;
         x_ff <= o_dx;
         y_ff <= o_dy;
      end else begin
         t_ff <= '{valid: ot.valid, op: ot.op, clamped: ot.clamped | dist_c,
                   error: ot.error};
         x_ff <= sat32(ux);
         y_ff <= sat32(uy);
      end
   end

   assign out_valid = v_ff;
   assign out_tag   = t_ff;
   assign out_xn    = xn_ff;
   assign out_yn    = yn_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
endmodule
`default_nettype wire

@@ rtl/lens_distortion_point_map_core.sv @@
`default_nettype none
// Brown-Conrady lens distortion point map.
//
// Configuration registers are written on the csr_ channel (csr_valid and
// csr_ready, index csr_index, data csr_wdata); csr_ready is always high and
// writes beyond the eighth register are ignored. Write only while idle.
// A transaction enters when start is high and busy is low; busy stays low,
// so one coordinate pair can enter in every clock cycle.
// The pair is normalised by two pipelined dividers, then runs through an
// unrolled chain of UNDISTORT_ITERATIONS model steps, each step being a
// pipelined model evaluator followed by two pipelined 62-bit dividers.
// Distortion (opcode 1) is worked on in the first step only; the later steps
// pass its result through unchanged, so every transaction has the same delay.
// Normalisation, every step and the output stages are pipelined, with dividers
// that resolve one bit per stage; throughput is one transaction per cycle.
// Each result appears on rsp_ for one cycle marked by rsp_strobe; the
// receiver cannot stall. Reset clears every valid bit and returns the lens
// registers to their reset values.
module lens_distortion_point_map_core
   import ldpm_pkg::*;
#(
   parameter int unsigned UNDISTORT_ITERATIONS = IterDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_opcode,
   input  wire logic signed [31:0] req_pixel_x,
   input  wire logic signed [31:0] req_pixel_y,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_mapped_x,
   output logic signed [31:0]      rsp_mapped_y,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);
   cfg_type cfg_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{focal_x: 32'h0001_0000, focal_y: 32'h0001_0000, default: '0};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            RegFocalX:  cfg_ff.focal_x  <= csr_wdata;
            RegFocalY:  cfg_ff.focal_y  <= csr_wdata;
            RegCenterX: cfg_ff.center_x <= csr_wdata;
            RegCenterY: cfg_ff.center_y <= csr_wdata;
            RegK1:      cfg_ff.k1       <= csr_wdata;
            RegK2:      cfg_ff.k2       <= csr_wdata;
            RegP1:      cfg_ff.p1       <= csr_wdata;
            RegP2:      cfg_ff.p2       <= csr_wdata;
            default:    cfg_ff          <= cfg_ff;
         endcase
      end
   end

   logic [31:0] fx, fy;
   assign fx = (cfg_ff.focal_x == '0) ? 32'd1 : cfg_ff.focal_x;
   assign fy = (cfg_ff.focal_y == '0) ? 32'd1 : cfg_ff.focal_y;

   // Normalisation: (pixel - centre) * 2^28 / focal.
   logic signed [32:0] ox, oy;
   assign ox = 33'(req_pixel_x) - 33'(cfg_ff.center_x);
   assign oy = 33'(req_pixel_y) - 33'(cfg_ff.center_y);

   logic nv_x, nv_y, nop, nop_y;
   logic signed [61:0] nqx, nqy;
   ldpm_div #(.NumBits(61), .DenBits(32), .TagBits(1)) u_norm_x (
      .clock, .reset, .in_valid(start && !busy),
      .num({ox, 28'd0}), .den(fx), .in_tag(req_opcode),
      .out_valid(nv_x), .quo(nqx), .out_tag(nop)
   );
   ldpm_div #(.NumBits(61), .DenBits(32), .TagBits(1)) u_norm_y (
      .clock, .reset, .in_valid(start && !busy),
      .num({oy, 28'd0}), .den(fy), .in_tag(req_opcode),
      .out_valid(nv_y), .quo(nqy), .out_tag(nop_y)
   );

   logic               s_valid [UNDISTORT_ITERATIONS+1];
   tag_type            s_tag   [UNDISTORT_ITERATIONS+1];
   logic signed [31:0] s_xn    [UNDISTORT_ITERATIONS+1];
   logic signed [31:0] s_yn    [UNDISTORT_ITERATIONS+1];
   logic signed [31:0] s_x     [UNDISTORT_ITERATIONS+1];
   logic signed [31:0] s_y     [UNDISTORT_ITERATIONS+1];

   logic               n_v_ff;
   tag_type            n_t_ff;
   logic signed [31:0] n_x_ff, n_y_ff;
   always_ff @(posedge clock) begin
      if (reset) n_v_ff <= 1'b0;
      else       n_v_ff <= nv_x & nv_y;
   end
   always_ff @(posedge clock) begin
      n_t_ff <= '{valid: 1'b1, op: nop | (nop_y & 1'b0),
                  clamped: ovf32(66'(nqx)) | ovf32(66'(nqy)), error: 1'b0};
      n_x_ff <= sat32(66'(nqx));
      n_y_ff <= sat32(66'(nqy));
   end

   assign s_valid[0] = n_v_ff;
   assign s_tag[0]   = n_t_ff;
   assign s_xn[0]    = n_x_ff;
   assign s_yn[0]    = n_y_ff;
   assign s_x[0]     = n_x_ff;
   assign s_y[0]     = n_y_ff;

   // Distortion uses only the first step; later steps pass its result through.
   for (genvar i = 0; i < UNDISTORT_ITERATIONS; i++) begin : g_it
      logic               iv;
      tag_type            it;
      logic signed [31:0] ixn, iyn, ix, iy;
      ldpm_iter u_iter (
         .clock, .reset, .cfg(cfg_ff), .first_step(i == 0),
         .in_valid(s_valid[i]), .in_tag(s_tag[i]),
         .xn(s_xn[i]), .yn(s_yn[i]), .x(s_x[i]), .y(s_y[i]),
         .out_valid(iv), .out_tag(it), .out_xn(ixn), .out_yn(iyn),
         .out_x(ix), .out_y(iy)
      );
      assign s_valid[i+1] = iv;
      assign s_tag[i+1]   = it;
      assign s_xn[i+1]    = ixn;
      assign s_yn[i+1]    = iyn;
      assign s_x[i+1]     = ix;
      assign s_y[i+1]     = iy;
   end

   // Back to pixels: floor(x * f / 2^28) + centre.
   localparam int unsigned L = UNDISTORT_ITERATIONS;
   logic               p_v_ff, o_v_ff;
   tag_type            p_t_ff;
   logic signed [64:0] p_x_ff, p_y_ff;
   logic signed [65:0] mx, my;
   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         p_v_ff <= s_valid[L];
         o_v_ff <= p_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      p_t_ff <= s_tag[L];
      p_x_ff <= s_x[L] * $signed({1'b0, fx});
      p_y_ff <= s_y[L] * $signed({1'b0, fy});
   end
   always_comb begin
      mx = 66'(p_x_ff >>> 28) + 66'(cfg_ff.center_x);
      my = 66'(p_y_ff >>> 28) + 66'(cfg_ff.center_y);
   end
   always_ff @(posedge clock) begin
      if (p_t_ff.error) begin
         rsp_mapped_x <= '0;
         rsp_mapped_y <= '0;
         rsp_status   <= StatusRadial;
      end else begin
         rsp_mapped_x <= sat32(mx);
         rsp_mapped_y <= sat32(my);
         rsp_status   <= (p_t_ff.clamped | ovf32(mx) | ovf32(my)) ? StatusSat
                                                                  : StatusOk;
      end
   end
   assign rsp_strobe = o_v_ff;

   a_busy_low: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status != 2'd3)) else $error("bad status");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == StatusRadial) |-> (rsp_mapped_x == 0 && rsp_mapped_y == 0))
      else $error("error result not zero");
endmodule
`default_nettype wire

@@ sim/lens_distortion_point_map_core_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none

module lens_distortion_point_map_core_tb;
   import ldpm_pkg::*;

   // One expected coordinate pair with its status code.
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [1:0]         st;
   } mapped_point_type;

   // Keeps a private copy of the lens registers, predicts the mapped point for every
   // accepted transaction and compares each returned point with the oldest prediction.
   class lens_map_scoreboard;
      cfg_type          lens;
      mapped_point_type pending_points[$];
      int               failures;
      bit               clamped;

      function new();
         lens = '0;
         lens.focal_x = 32'h0001_0000;
         lens.focal_y = 32'h0001_0000;
         failures = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            RegFocalX:  lens.focal_x  = data;
            RegFocalY:  lens.focal_y  = data;
            RegCenterX: lens.center_x = data;
            RegCenterY: lens.center_y = data;
            RegK1:      lens.k1       = data;
            RegK2:      lens.k2       = data;
            RegP1:      lens.p1       = data;
            default:    lens.p2       = data;
         endcase
      endfunction

      function longint clip(longint v);
         if (v > 64'sd2147483647) begin
            clamped = 1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            clamped = 1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      // Q4.28 product, rounded towards minus infinity.
      function longint qmul(longint a, longint b);
         return clip((a * b) >>> 28);
      endfunction

      function void lens_terms(longint x, longint y, output longint radial,
                               output longint tx, output longint ty);
         longint xx, yy, xy, r2, r4;
         xx = qmul(x, x);
         yy = qmul(y, y);
         xy = qmul(x, y);
         r2 = clip(xx + yy);
         r4 = qmul(r2, r2);
         radial = clip((64'sd1 <<< 28) + qmul(lens.k1, r2) + qmul(lens.k2, r4));
         tx = clip(2 * qmul(lens.p1, xy) + qmul(lens.p2, clip(r2 + 2 * xx)));
         ty = clip(qmul(lens.p1, clip(r2 + 2 * yy)) + 2 * qmul(lens.p2, xy));
      endfunction

      function void note_input(logic op, logic signed [31:0] px, logic signed [31:0] py);
         longint           fx, fy, cx, cy, xn, yn, x, y, radial, tx, ty;
         mapped_point_type pt;
         bit               radial_fault;
         clamped = 0;
         radial_fault = 0;
         // A focal length of zero behaves as the smallest step.
         fx = (lens.focal_x == 0) ? 64'sd1 : longint'({32'b0, lens.focal_x});
         fy = (lens.focal_y == 0) ? 64'sd1 : longint'({32'b0, lens.focal_y});
         cx = lens.center_x;
         cy = lens.center_y;
         xn = clip(((longint'(px) - cx) <<< 28) / fx);
         yn = clip(((longint'(py) - cy) <<< 28) / fy);
         if (op == OpDistort) begin
            lens_terms(xn, yn, radial, tx, ty);
            x = clip(qmul(xn, radial) + tx);
            y = clip(qmul(yn, radial) + ty);
         end else begin
            x = xn;
            y = yn;
            for (int i = 0; i < IterDefault && !radial_fault; i++) begin
               lens_terms(x, y, radial, tx, ty);
               if (radial <= 0) begin
                  radial_fault = 1;
               end else begin
                  x = clip(((xn - tx) <<< 28) / radial);
                  y = clip(((yn - ty) <<< 28) / radial);
               end
            end
         end
         if (radial_fault) begin
            pt.x = 0;
            pt.y = 0;
            pt.st = StatusRadial;
         end else begin
            pt.x = clip(((x * fx) >>> 28) + cx);
            pt.y = clip(((y * fy) >>> 28) + cy);
            pt.st = clamped ? StatusSat : StatusOk;
         end
         pending_points = {pending_points, pt};
      endfunction

      function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                                 logic [1:0] st);
         mapped_point_type pt;
         if (pending_points.size() == 0) begin
            $error("unexpected result x=%0d y=%0d status=%0d", x, y, st);
            failures++;
            return;
         end
         pt = pending_points.pop_front();
         if (x !== pt.x) begin
            $error("mapped_x: expected %0d, got %0d", pt.x, x);
            failures++;
         end
         if (y !== pt.y) begin
            $error("mapped_y: expected %0d, got %0d", pt.y, y);
            failures++;
         end
         if (st !== pt.st) begin
            $error("status: expected %0d, got %0d", pt.st, st);
            failures++;
         end
      endfunction
   endclass

   localparam int StallLimit  = 5000;
   localparam int DrainCycles = 900;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_opcode;
   logic signed [31:0] req_pixel_x;
   logic signed [31:0] req_pixel_y;
   logic               rsp_strobe;
   logic signed [31:0] rsp_mapped_x;
   logic signed [31:0] rsp_mapped_y;
   logic [1:0]         rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   lens_map_scoreboard sb;
   int                 accepted_items;
   int                 accepted_writes;
   int                 quiet_cycles;
   int                 idle_pct;

   lens_distortion_point_map_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_pixel_x  (req_pixel_x),
      .req_pixel_y  (req_pixel_y),
      .rsp_strobe   (rsp_strobe),
      .rsp_mapped_x (rsp_mapped_x),
      .rsp_mapped_y (rsp_mapped_y),
      .rsp_status   (rsp_status),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Every handshake is observed here, at the rising edge, with the values that the
   // block itself sees. The watchdog counts the cycles in which nothing at all moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_input(req_opcode, req_pixel_x, req_pixel_y);
            accepted_items <= accepted_items + 1;
         end
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_wdata);
            accepted_writes <= accepted_writes + 1;
         end
         if (rsp_strobe)
            sb.check_result(rsp_mapped_x, rsp_mapped_y, rsp_status);
         if ((start && !busy) || (csr_valid && csr_ready) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= StallLimit) begin
            $display("lens_distortion_point_map_core verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offers one transaction and holds it until the block has taken it. The sender
   // first idles at random, according to the current phase.
   task automatic send_point(logic op, logic signed [31:0] px, logic signed [31:0] py);
      int target;
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      target = accepted_items + 1;
      start = 1'b1;
      req_opcode = op;
      req_pixel_x = px;
      req_pixel_y = py;
      do @(negedge clock); while (accepted_items != target);
      start = 1'b0;
   endtask

   // Holds the sender back until every outstanding transaction has returned.
   task automatic wait_drained();
      start = 1'b0;
      while (sb.pending_points.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      int target;
      target = accepted_writes + 1;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(negedge clock); while (accepted_writes != target);
      csr_valid = 1'b0;
   endtask

   // Registers are only ever rewritten once the pipeline has emptied.
   task automatic load_lens(cfg_type c);
      wait_drained();
      write_reg(RegFocalX, c.focal_x);
      write_reg(RegFocalY, c.focal_y);
      write_reg(RegCenterX, c.center_x);
      write_reg(RegCenterY, c.center_y);
      write_reg(RegK1, c.k1);
      write_reg(RegK2, c.k2);
      write_reg(RegP1, c.p1);
      write_reg(RegP2, c.p2);
   endtask

   // A plausible camera: focal lengths of a few hundred to a few thousand pixels,
   // the principal point near the image centre and modest coefficients.
   function automatic cfg_type camera_lens();
      cfg_type c;
      c.focal_x  = $urandom_range(3000, 200) << 16;
      c.focal_y  = $urandom_range(3000, 200) << 16;
      c.center_x = $urandom_range(1000, 100) << 16;
      c.center_y = $urandom_range(800, 100) << 16;
      c.k1 = $signed($urandom_range(2 * 134217728)) - 134217728;
      c.k2 = $signed($urandom_range(2 * 67108864)) - 67108864;
      c.p1 = $signed($urandom_range(2 * 8388608)) - 8388608;
      c.p2 = $signed($urandom_range(2 * 8388608)) - 8388608;
      return c;
   endfunction

   function automatic cfg_type random_lens();
      cfg_type c;
      c.focal_x  = $urandom;
      c.focal_y  = $urandom;
      c.center_x = $urandom;
      c.center_y = $urandom;
      c.k1 = $urandom;
      c.k2 = $urandom;
      c.p1 = $urandom;
      c.p2 = $urandom;
      return c;
   endfunction

   // Mostly points that fall on the image, some anywhere in the full signed range.
   task automatic random_points(int count);
      logic               op;
      logic signed [31:0] px;
      logic signed [31:0] py;
      for (int i = 0; i < count; i++) begin
         op = $urandom_range(1);
         if ($urandom_range(99) < 75) begin
            px = $urandom_range(2000 << 16);
            py = $urandom_range(1600 << 16);
         end else begin
            px = $urandom;
            py = $urandom;
         end
         send_point(op, px, py);
      end
   endtask

   initial begin
      cfg_type c;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OpUndistort;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_valid = 1'b0;
      csr_index = RegFocalX;
      csr_wdata = '0;
      accepted_items = 0;
      accepted_writes = 0;
      quiet_cycles = 0;
      idle_pct = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed part, first under the reset values: unit focal lengths, no distortion.
      // Extreme pixels saturate during normalisation.
      send_point(OpDistort, 32'sh7fffffff, 32'sh80000000);
      send_point(OpUndistort, 32'sh7fffffff, 32'sh80000000);
      send_point(OpDistort, 0, 0);
      send_point(OpUndistort, 32'sh0000ffff, -32'sh00010000);

      // A strongly negative k1 drives the radial factor below zero away from the
      // centre: undistortion must report the fault, distortion simply goes on.
      c = camera_lens();
      c.k1 = 32'sh80000000;
      c.k2 = 32'sh80000000;
      load_lens(c);
      send_point(OpUndistort, c.center_x, c.center_y);
      send_point(OpUndistort, 32'sh7fffffff, 32'sh7fffffff);
      send_point(OpDistort, 32'sh7fffffff, 32'sh80000000);
      send_point(OpUndistort, 32'sh80000000, 0);

      // Zero focal lengths act as the smallest step; coefficients at the extremes.
      c.focal_x = 0;
      c.focal_y = 0;
      c.k1 = 32'sh7fffffff;
      c.k2 = 32'sh7fffffff;
      c.p1 = 32'sh7fffffff;
      c.p2 = 32'sh80000000;
      load_lens(c);
      send_point(OpDistort, c.center_x + 1, c.center_y - 1);
      send_point(OpUndistort, c.center_x + 1, c.center_y);
      send_point(OpDistort, 32'sh12345678, 32'sh87654321);

      // Largest focal lengths and principal point at the extremes.
      c.focal_x = 32'hffffffff;
      c.focal_y = 32'hffffffff;
      c.center_x = 32'sh80000000;
      c.center_y = 32'sh7fffffff;
      c.k1 = 0;
      c.k2 = 0;
      c.p1 = 32'sh80000000;
      c.p2 = 32'sh7fffffff;
      load_lens(c);
      send_point(OpDistort, 32'sh7fffffff, 32'sh80000000);
      send_point(OpUndistort, 32'sh7fffffff, 32'sh80000000);
      send_point(OpDistort, 0, 32'sh7fffffff);
      send_point(OpUndistort, 32'sh80000000, 0);

      // Random phases with different sender idling; each new lens is loaded only once
      // the pipeline has drained, so the sender also waits for every result.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 78;
            2: idle_pct = 15;
            default: idle_pct = $urandom_range(50);
         endcase
         load_lens((ph == 5) ? random_lens() : camera_lens());
         random_points(ph == 5 ? 40 : 80);
         if (ph == 2) begin
            wait_drained();
            random_points(10);
         end
      end

      wait_drained();
      repeat (DrainCycles) @(negedge clock);
      if (sb.failures == 0 && sb.pending_points.size() == 0) begin
         $display("lens_distortion_point_map_core verification clean");
      end else begin
         $display("lens_distortion_point_map_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
